[design/scpf_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// scpf_pkg: shared types and constants of the servo command packet framer
// Command codes, packet byte codes and the command and packet records.
// ----------------------------------------------------------------------------
package scpf_pkg;

    typedef enum logic [2:0] {
        OP_SET_ANGLE  = 3'd0,
        OP_SET_ID     = 3'd1,
        OP_SET_SPEED  = 3'd2,
        OP_SET_LED    = 3'd3,
        OP_READ_POS   = 3'd4,
        OP_READ_SPEED = 3'd5,
        OP_READ_LED   = 3'd6
    } op_t;

    localparam logic [7:0] START_MARK      = 8'hFF;
    localparam logic [7:0] INSTR_READ      = 8'h02;
    localparam logic [7:0] INSTR_WRITE     = 8'h03;
    localparam logic [7:0] ADDR_GOAL_POS   = 8'h1E;
    localparam logic [7:0] ADDR_MOVE_SPEED = 8'h20;
    localparam logic [7:0] ADDR_SERVO_ID   = 8'h03;
    localparam logic [7:0] ADDR_LED        = 8'h19;
    localparam logic [7:0] ADDR_POSITION   = 8'h24;
    localparam logic [7:0] ADDR_SPEED      = 8'h26;
    localparam logic [7:0] LEN_READ        = 8'h03;
    localparam logic [7:0] LEN_WRITE_ONE   = 8'h04;
    localparam logic [7:0] LEN_WRITE_TWO   = 8'h05;

    localparam logic [15:0] FULL_TURN_Q7 = 16'd46080;
    localparam logic [16:0] OFFSET_Q7    = 17'd19200;
    // floor(a * 341 / 12800) as (a * POS_RECIP) >> POS_SHIFT, exact for a < 46080
    localparam logic [24:0] POS_RECIP    = 25'd28605154;
    localparam int          POS_SHIFT    = 30;
    localparam int          POS_W        = 11;
    localparam int          PROD_W       = 41;

    localparam int          PKT_BODY     = 8;
    localparam int          LEN_W        = 4;
    localparam logic [LEN_W-1:0] NB_READ      = 4'd7;
    localparam logic [LEN_W-1:0] NB_WRITE_ONE = 4'd8;
    localparam logic [LEN_W-1:0] NB_WRITE_TWO = 4'd9;

    typedef struct packed {
        op_t         op;
        logic [7:0]  servo_id;
        logic [15:0] angle_q7;
        logic [7:0]  param_byte;
        logic        mirror;
        logic        left;
    } cmd_t;

    typedef struct packed {
        logic                          left;
        logic [LEN_W-1:0]              len;
        logic [7:0]                    cs;
        logic [PKT_BODY-1:0][7:0]      body;
    } pkt_t;

endpackage
`default_nettype wire

[design/scpf_pkt_build.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// scpf_pkt_build: instruction packet builder
// Turns one registered command into packet bytes, byte count and checksum.
// ----------------------------------------------------------------------------
module scpf_pkt_build (
    input  wire scpf_pkg::cmd_t cmd,
    output scpf_pkg::pkt_t      pkt
);

    logic [15:0]                     ang_sat;
    logic [15:0]                     ang_mir;
    logic [16:0]                     ang_off;
    logic [15:0]                     ang_wrap;
    logic [scpf_pkg::PROD_W-1:0]     prod;
    logic [scpf_pkg::POS_W-1:0]      pos;

    always_comb begin
        ang_sat  = (cmd.angle_q7 > scpf_pkg::FULL_TURN_Q7) ? scpf_pkg::FULL_TURN_Q7
                                                           : cmd.angle_q7;
        ang_mir  = cmd.mirror ? 16'(scpf_pkg::FULL_TURN_Q7 - ang_sat) : ang_sat;
        ang_off  = {1'b0, ang_mir} + scpf_pkg::OFFSET_Q7;
        if (ang_off >= {1'b0, scpf_pkg::FULL_TURN_Q7}) begin
            ang_wrap = 16'(ang_off - {1'b0, scpf_pkg::FULL_TURN_Q7});
        end else begin
            ang_wrap = 16'(ang_off);
        end
        prod = scpf_pkg::PROD_W'(ang_wrap) * scpf_pkg::PROD_W'(scpf_pkg::POS_RECIP);
        pos  = prod[scpf_pkg::POS_SHIFT +: scpf_pkg::POS_W];
    end

    logic [7:0] sum;

    always_comb begin
        pkt         = '0;
        pkt.left    = cmd.left;
        pkt.len     = scpf_pkg::NB_READ;
        pkt.body[0] = scpf_pkg::START_MARK;
        pkt.body[1] = scpf_pkg::START_MARK;
        pkt.body[2] = cmd.servo_id;
        case (cmd.op)
            scpf_pkg::OP_SET_ANGLE: begin
                pkt.len     = scpf_pkg::NB_WRITE_TWO;
                pkt.body[3] = scpf_pkg::LEN_WRITE_TWO;
                pkt.body[4] = scpf_pkg::INSTR_WRITE;
                pkt.body[5] = scpf_pkg::ADDR_GOAL_POS;
                pkt.body[6] = pos[7:0];
                pkt.body[7] = 8'(pos[scpf_pkg::POS_W-1:8]);
            end
            scpf_pkg::OP_SET_ID: begin
                pkt.len     = scpf_pkg::NB_WRITE_ONE;
                pkt.body[3] = scpf_pkg::LEN_WRITE_ONE;
                pkt.body[4] = scpf_pkg::INSTR_WRITE;
                pkt.body[5] = scpf_pkg::ADDR_SERVO_ID;
                pkt.body[6] = cmd.param_byte;
            end
            scpf_pkg::OP_SET_SPEED: begin
                pkt.len     = scpf_pkg::NB_WRITE_TWO;
                pkt.body[3] = scpf_pkg::LEN_WRITE_TWO;
                pkt.body[4] = scpf_pkg::INSTR_WRITE;
                pkt.body[5] = scpf_pkg::ADDR_MOVE_SPEED;
                pkt.body[6] = cmd.param_byte;
            end
            scpf_pkg::OP_SET_LED: begin
                pkt.len     = scpf_pkg::NB_WRITE_ONE;
                pkt.body[3] = scpf_pkg::LEN_WRITE_ONE;
                pkt.body[4] = scpf_pkg::INSTR_WRITE;
                pkt.body[5] = scpf_pkg::ADDR_LED;
                pkt.body[6] = cmd.param_byte;
            end
            scpf_pkg::OP_READ_POS: begin
                pkt.body[3] = scpf_pkg::LEN_READ;
                pkt.body[4] = scpf_pkg::INSTR_READ;
                pkt.body[5] = scpf_pkg::ADDR_POSITION;
            end
            scpf_pkg::OP_READ_SPEED: begin
                pkt.body[3] = scpf_pkg::LEN_READ;
                pkt.body[4] = scpf_pkg::INSTR_READ;
                pkt.body[5] = scpf_pkg::ADDR_SPEED;
            end
            default: begin
                pkt.body[3] = scpf_pkg::LEN_READ;
                pkt.body[4] = scpf_pkg::INSTR_READ;
                pkt.body[5] = scpf_pkg::ADDR_LED;
            end
        endcase
        sum = '0;
        for (int k = 2; k < scpf_pkg::PKT_BODY; k++) begin
            sum = sum + pkt.body[k];
        end
        pkt.cs = ~sum;
    end

endmodule
`default_nettype wire

[design/servo_command_packet_framer.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// servo_command_packet_framer: servo bus instruction packet framer
// Takes one servo command per beat and sends its instruction packet
// one byte per beat.
//
// s_ channel: one command per beat, fields in s_tdata.
// m_ channel: one packet byte per beat in m_tdata; m_tuser is the bus side
//   (1 left, 0 right), the same on every byte; m_tlast marks the checksum.
// A packet is 7, 8 or 9 bytes long (reads, one-byte writes, two-byte
// writes); the serialiser gives one byte per cycle while the receiver is
// ready, so the sustained command rate is set by the output byte stream.
// A command goes through the input register, then the packet register.
// The next command is taken into the input register while the current
// packet is still going out, and moves into the packet register in the
// cycle its last byte is taken, so packets follow back to back.
// A command with the unused op code produces no packet and is dropped.
// Reset clears both valid flags and the byte index; no packet is pending.
// When the receiver stalls, the current byte holds and the input side
// stops taking commands once the input register is full.
// ----------------------------------------------------------------------------
module servo_command_packet_framer (
    input  wire         aclk,
    input  wire         aresetn,
    input  wire         s_tvalid,
    output logic        s_tready,
    // op [2:0], servo_id [10:3], angle_q7 [26:11], param_byte [34:27]
    input  wire  [39:0] s_tdata,
    output logic        m_tvalid,
    input  wire         m_tready,
    // tx_byte [7:0]
    output logic [7:0]  m_tdata,
    // left_bus [0]
    output logic [0:0]  m_tuser,
    output logic        m_tlast
);

    scpf_pkg::cmd_t             cmd_reg;
    logic                       cmd_valid_reg;
    scpf_pkg::pkt_t             pkt_reg;
    scpf_pkg::pkt_t             pkt_next;
    logic                       pkt_valid_reg;
    logic [scpf_pkg::LEN_W-1:0] idx_reg;

    logic       s_beat;
    logic       m_beat;
    logic       pkt_load;
    logic       last;
    logic       op_ok;
    logic [7:0] id_dec;
    logic [15:0] cls_prod;
    logic [7:0] cls_quo;
    logic [7:0] cls_six;
    logic [2:0] cls;
    scpf_pkg::cmd_t cmd_next;

    // class = (id - 1) mod 6, quotient by reciprocal 171 / 1024
    always_comb begin
        id_dec   = s_tdata[10:3] - 8'd1;
        cls_prod = 16'(id_dec) * 16'd171;
        cls_quo  = 8'(cls_prod[15:10]);
        cls_six  = 8'(cls_quo * 8'd6);
        cls      = 3'(id_dec - cls_six);
    end

    always_comb begin
        cmd_next.op         = scpf_pkg::op_t'(s_tdata[2:0]);
        cmd_next.servo_id   = s_tdata[10:3];
        cmd_next.angle_q7   = s_tdata[26:11];
        cmd_next.param_byte = s_tdata[34:27];
        cmd_next.left       = (s_tdata[10:3] != 8'd0) && (cls >= 3'd3);
        cmd_next.mirror     = (s_tdata[10:3] != 8'd0) && (cls inside {3'd0, 3'd2, 3'd3, 3'd4});
        op_ok               = cmd_next.op <= scpf_pkg::OP_READ_LED;
    end

    scpf_pkt_build u_build (
        .cmd (cmd_reg),
        .pkt (pkt_next)
    );

    assign last     = idx_reg == pkt_reg.len - 4'd1;
    assign m_beat   = m_tvalid && m_tready;
    assign pkt_load = cmd_valid_reg && (!pkt_valid_reg || (m_beat && last));
    assign s_tready = !cmd_valid_reg || pkt_load;
    assign s_beat   = s_tvalid && s_tready;

    assign m_tvalid = pkt_valid_reg;
    assign m_tdata  = last ? pkt_reg.cs : pkt_reg.body[idx_reg[2:0]];
    assign m_tuser  = pkt_reg.left;
    assign m_tlast  = last;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cmd_valid_reg <= 1'b0;
            pkt_valid_reg <= 1'b0;
            idx_reg       <= '0;
        end else begin
            if (s_beat) begin
                cmd_valid_reg <= op_ok;
            end else if (pkt_load) begin
                cmd_valid_reg <= 1'b0;
            end
            if (pkt_load) begin
                pkt_valid_reg <= 1'b1;
            end else if (m_beat && last) begin
                pkt_valid_reg <= 1'b0;
            end
            if (m_beat) begin
                idx_reg <= last ? '0 : idx_reg + 4'd1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_beat) begin
            cmd_reg <= cmd_next;
        end
        if (pkt_load) begin
            pkt_reg <= pkt_next;
        end
    end

`ifndef SYNTH
    a_idx_in_pkt: assert property (@(posedge aclk) disable iff (!aresetn)
        pkt_valid_reg |-> (idx_reg < pkt_reg.len))
        else $error("byte index beyond packet length");

    a_start_mark: assert property (@(posedge aclk) disable iff (!aresetn)
        (pkt_valid_reg && idx_reg == '0) |-> (m_tdata == scpf_pkg::START_MARK))
        else $error("packet does not open with start mark");

    a_drain: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_beat && last && !pkt_load) |=> !m_tvalid)
        else $error("packet register not freed after last beat");

    a_cmd_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd_valid_reg && !pkt_load) |=> (cmd_valid_reg && $stable(cmd_reg)))
        else $error("pending command lost");

    a_idx_restart: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_beat && last) |=> (idx_reg == '0))
        else $error("byte index not restarted");
`endif

endmodule
`default_nettype wire
